FILE: hw/rtl/rvgt_pkg.sv
`timescale 1ns / 1ps
package rvgt_pkg;

   // Grid size limits.
   localparam int MaxCells   = 16;
   localparam int MaxResults = 3 * MaxCells - 2;
   localparam int CntW       = $clog2(MaxResults);

   // Datapath widths for the exact rational arithmetic.
   localparam int HiW   = 38;   // far corner of the box
   localparam int DistW = 39;   // slab distances and plane distances
   localparam int ProdW = 56;   // distance times direction magnitude
   localparam int NumW  = 57;   // entry cell numerator
   localparam int DenW  = 47;   // cell size times direction magnitude
   localparam int PW    = 58;   // walk time products
   localparam int KW    = 47;   // walk time increments

   // Register index codes of the control port.
   localparam int CsrIdxW = 3;
   localparam logic [CsrIdxW-1:0] CSR_GRID_MIN_X  = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_GRID_MIN_Y  = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_GRID_MIN_Z  = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_CELL_SIZE_X = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_CELL_SIZE_Y = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_CELL_SIZE_Z = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_CELLS       = 3'd6;

   // Axis codes and the top bit of the entry cell quotient.
   localparam logic [1:0] AxisX  = 2'd0;
   localparam logic [1:0] AxisY  = 2'd1;
   localparam logic [1:0] AxisZ  = 2'd2;
   localparam logic [1:0] DivTop = 2'd3;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
   } req_word_type;

   typedef struct packed {
      logic [3:0] cell_x;
      logic [3:0] cell_y;
      logic [3:0] cell_z;
      logic       hit;
      logic       last;
   } rsp_word_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_PREP,
      OP_SLAB_MUL,
      OP_SLAB_UPD,
      OP_CHK_MUL,
      OP_ENT_MUL,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_DIST,
      OP_PROD,
      OP_WALK,
      OP_MISS
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_SLAB_MUL,
      ST_SLAB_UPD,
      ST_CHK_MUL,
      ST_CHK_UPD,
      ST_ENT_MUL,
      ST_DIV_INIT,
      ST_DIV_STEP,
      ST_DIST,
      ST_PROD,
      ST_WALK,
      ST_MISS
   } state_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] axis;
      logic [1:0] bit_idx;
   } cmd_type;

   typedef struct packed {
      logic pass;
      logic walk_last;
      logic slot_free;
   } stat_type;

   // A zero cell size is taken as one.
   function automatic logic [30:0] eff_size(input logic [30:0] s);
      eff_size = (s == 31'd0) ? 31'd1 : s;
   endfunction

   // Cell count clamped to one .. MaxCells.
   function automatic logic [4:0] eff_cells(input logic [4:0] n);
      if (n == 5'd0) begin
         eff_cells = 5'd1;
      end else if (n > 5'(MaxCells)) begin
         eff_cells = 5'(MaxCells);
      end else begin
         eff_cells = n;
      end
   endfunction

endpackage

FILE: hw/rtl/ray_voxel_grid_traversal.sv
`timescale 1ns / 1ps
// Channel   Ports                        Word
// request   req_valid req_stall          req_word: ray origin and direction
// result    rsp_valid rsp_stall          rsp_word: visited cell, hit, last
// control   csr_write csr_index csr_data grid corner, cell sizes, cell count
//
// A ray's set-up runs load, box bounds, three slab tests (multiply, update),
// a final check (multiply, update), the entry cell per axis (multiply, divider
// set-up, four restoring divide steps, next plane) and the step tables; then
// the walk gives one visited cell per cycle while the result word is not
// stalled, at most 46 cells. A missed box gives its one word after the check.
// Reset is synchronous and restores the control registers.
// A stalled result word holds the walk; the next ray is taken once the last
// word of the previous ray sits in the output register.
module ray_voxel_grid_traversal (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  rvgt_pkg::req_word_type       req_word,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output rvgt_pkg::rsp_word_type       rsp_word,
   input  logic                         csr_write,
   input  logic [rvgt_pkg::CsrIdxW-1:0] csr_index,
   input  logic [31:0]                  csr_data
);
   import rvgt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   rvgt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   rvgt_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .stat      (stat),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // A miss is always the only and final word of its ray.
   miss_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.hit |-> rsp_word.last)
      else $error("miss word without last");

   // A miss carries cell zero on every axis.
   miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.hit |->
         (rsp_word.cell_x == 4'd0) && (rsp_word.cell_y == 4'd0) && (rsp_word.cell_z == 4'd0))
      else $error("miss word with a non-zero cell");

   // Once a ray is taken the block works on it and takes no other.
   busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second ray taken during set-up");

endmodule

FILE: hw/rtl/rvgt_ctrl.sv
`timescale 1ns / 1ps
module rvgt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  rvgt_pkg::stat_type stat,
   output rvgt_pkg::cmd_type  cmd
);
   import rvgt_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic [1:0] bit_ff, bit_in;

   // Next state and the axis and quotient bit counters.
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      bit_in   = bit_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_SLAB_MUL;
            axis_in  = AxisX;
         end
         ST_SLAB_MUL: begin
            state_in = ST_SLAB_UPD;
         end
         ST_SLAB_UPD: begin
            if (axis_ff == AxisZ) begin
               state_in = ST_CHK_MUL;
               axis_in  = AxisX;
            end else begin
               state_in = ST_SLAB_MUL;
               axis_in  = axis_ff + 2'd1;
            end
         end
         ST_CHK_MUL: begin
            state_in = ST_CHK_UPD;
         end
         ST_CHK_UPD: begin
            state_in = stat.pass ? ST_ENT_MUL : ST_MISS;
         end
         ST_ENT_MUL: begin
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            state_in = ST_DIV_STEP;
            bit_in   = DivTop;
         end
         ST_DIV_STEP: begin
            if (bit_ff == 2'd0) begin
               state_in = ST_DIST;
            end else begin
               bit_in = bit_ff - 2'd1;
            end
         end
         ST_DIST: begin
            if (axis_ff == AxisZ) begin
               state_in = ST_PROD;
               axis_in  = AxisX;
            end else begin
               state_in = ST_ENT_MUL;
               axis_in  = axis_ff + 2'd1;
            end
         end
         ST_PROD: begin
            if (axis_ff == AxisZ) begin
               state_in = ST_WALK;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         ST_WALK: begin
            if (stat.slot_free && stat.walk_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_MISS: begin
            if (stat.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      req_stall   = 1'b1;
      cmd.op      = OP_NONE;
      cmd.axis    = axis_ff;
      cmd.bit_idx = bit_ff;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op = OP_LOAD;
            end
         end
         ST_PREP:     cmd.op = OP_PREP;
         ST_SLAB_MUL: cmd.op = OP_SLAB_MUL;
         ST_SLAB_UPD: cmd.op = OP_SLAB_UPD;
         ST_CHK_MUL:  cmd.op = OP_CHK_MUL;
         ST_CHK_UPD:  cmd.op = OP_NONE;
         ST_ENT_MUL:  cmd.op = OP_ENT_MUL;
         ST_DIV_INIT: cmd.op = OP_DIV_INIT;
         ST_DIV_STEP: cmd.op = OP_DIV_STEP;
         ST_DIST:     cmd.op = OP_DIST;
         ST_PROD:     cmd.op = OP_PROD;
         ST_WALK: begin
            if (stat.slot_free) begin
               cmd.op = OP_WALK;
            end
         end
         ST_MISS: begin
            if (stat.slot_free) begin
               cmd.op = OP_MISS;
            end
         end
         default: cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= AxisX;
         bit_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         bit_ff   <= bit_in;
      end
   end

endmodule

FILE: hw/rtl/rvgt_dpath.sv
`timescale 1ns / 1ps
module rvgt_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rvgt_pkg::req_word_type               req_word,
   input  rvgt_pkg::cmd_type                    cmd,
   output rvgt_pkg::stat_type                   stat,
   input  logic                                 csr_write,
   input  logic [rvgt_pkg::CsrIdxW-1:0]         csr_index,
   input  logic [31:0]                          csr_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output rvgt_pkg::rsp_word_type               rsp_word
);
   import rvgt_pkg::*;

   // Control registers.
   logic signed [31:0] grid_min_ff [3], grid_min_in [3];
   logic [30:0]        cell_size_ff [3], cell_size_in [3];
   logic [4:0]         cells_ff, cells_in;

   // Ray and slab state.
   logic signed [31:0]      org_ff [3], org_in [3];
   logic signed [15:0]      dir_ff [3], dir_in [3];
   logic signed [HiW-1:0]   hi_ff [3], hi_in [3];
   logic [15:0]             ad_ff [3], ad_in [3];
   logic signed [DistW-1:0] en_ff, en_in, xn_ff, xn_in;
   logic [15:0]             ed_ff, ed_in, xd_ff, xd_in;
   logic                    ok_ff, ok_in, have_exit_ff, have_exit_in;
   logic signed [DistW-1:0] near_ff, near_in, far_ff, far_in;
   logic signed [ProdW-1:0] pa_ff, pa_in, pb_ff, pb_in, pc_ff, pc_in, pd_ff, pd_in;

   // Entry cell divider.
   logic [DenW-1:0]   den_ff, den_in;
   logic [ProdW-1:0]  rem_ff, rem_in;
   logic [3:0]        q_ff, q_in;
   logic              neg_ff, neg_in, sat_ff, sat_in;

   // Walk state.
   logic [3:0]              c_ff [3], c_in [3];
   logic signed [DistW-1:0] dist_ff [3], dist_in [3];
   logic signed [PW-1:0]    p_ff [3][3], p_in [3][3];
   logic [KW-1:0]           k_ff [3][3], k_in [3][3];
   logic [CntW-1:0]         cnt_ff, cnt_in;

   // Output register.
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   // Selected axis operands.
   logic [30:0]             cs_e [3];
   logic [4:0]              n_e;
   logic [35:0]             span [3];
   logic signed [DistW-1:0] o_s, lo_s, hi_s;
   logic signed [15:0]      d_s;
   logic [15:0]             ad_s;
   logic [30:0]             cs_s;
   logic                    dzero, dpos;

   // Walk decision.
   logic       lt10, lt20, lt21;
   logic [1:0] best;
   logic       best_ok;
   logic       step_out;
   logic       last_w;

   // Division and plane helpers.
   logic signed [NumW-1:0]  num;
   logic [ProdW-1:0]        dshift;
   logic [3:0]              nm1, cfin;
   logic [4:0]              cfac;
   logic [35:0]             cspan;
   logic signed [DistW-1:0] plane;

   always_comb begin
      n_e = eff_cells(cells_ff);
      for (int a = 0; a < 3; a++) begin
         cs_e[a] = eff_size(cell_size_ff[a]);
         span[a] = 36'(cs_e[a]) * 36'(n_e);
      end
      o_s   = DistW'(org_ff[cmd.axis]);
      lo_s  = DistW'(grid_min_ff[cmd.axis]);
      hi_s  = DistW'(hi_ff[cmd.axis]);
      d_s   = dir_ff[cmd.axis];
      ad_s  = ad_ff[cmd.axis];
      cs_s  = cs_e[cmd.axis];
      dzero = (d_s == 16'sd0);
      dpos  = !d_s[15] && !dzero;
   end

   // Entry cell: quotient clamp and the distance to the next plane.
   always_comb begin
      num = NumW'(pa_ff) + NumW'(pb_ff);
      case (cmd.bit_idx)
         2'd0:    dshift = {9'b0, den_ff};
         2'd1:    dshift = {8'b0, den_ff, 1'b0};
         2'd2:    dshift = {7'b0, den_ff, 2'b0};
         default: dshift = {6'b0, den_ff, 3'b0};
      endcase
      nm1 = 4'(n_e - 5'd1);
      if (neg_ff) begin
         cfin = 4'd0;
      end else if (sat_ff || (q_ff > nm1)) begin
         cfin = nm1;
      end else begin
         cfin = q_ff;
      end
      cfac  = dpos ? ({1'b0, cfin} + 5'd1) : {1'b0, cfin};
      cspan = 36'(cfac) * 36'(cs_s);
      plane = lo_s + $signed({3'b0, cspan});
   end

   // Axis with the earliest next crossing; ties go to the lower axis.
   always_comb begin
      lt10 = p_ff[1][0] < p_ff[0][1];
      lt20 = p_ff[2][0] < p_ff[0][2];
      lt21 = p_ff[2][1] < p_ff[1][2];
      best    = AxisX;
      best_ok = (dir_ff[0] != 16'sd0);
      if ((dir_ff[1] != 16'sd0) && (!best_ok || lt10)) begin
         best    = AxisY;
         best_ok = 1'b1;
      end
      if ((dir_ff[2] != 16'sd0) && (!best_ok || ((best == AxisY) ? lt21 : lt20))) begin
         best    = AxisZ;
         best_ok = 1'b1;
      end
      if (dir_ff[best][15]) begin
         step_out = (c_ff[best] == 4'd0);
      end else begin
         step_out = (({1'b0, c_ff[best]} + 5'd1) >= n_e);
      end
      last_w = (cnt_ff == CntW'(MaxResults - 1)) || !best_ok || step_out;
   end

   // Next register values.
   always_comb begin
      grid_min_in  = grid_min_ff;
      cell_size_in = cell_size_ff;
      cells_in     = cells_ff;
      org_in       = org_ff;
      dir_in       = dir_ff;
      hi_in        = hi_ff;
      ad_in        = ad_ff;
      en_in        = en_ff;
      ed_in        = ed_ff;
      xn_in        = xn_ff;
      xd_in        = xd_ff;
      ok_in        = ok_ff;
      have_exit_in = have_exit_ff;
      near_in      = near_ff;
      far_in       = far_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      pc_in        = pc_ff;
      pd_in        = pd_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      neg_in       = neg_ff;
      sat_in       = sat_ff;
      c_in         = c_ff;
      dist_in      = dist_ff;
      p_in         = p_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;

      // Control register writes.
      if (csr_write) begin
         case (csr_index)
            CSR_GRID_MIN_X:  grid_min_in[0]  = csr_data;
            CSR_GRID_MIN_Y:  grid_min_in[1]  = csr_data;
            CSR_GRID_MIN_Z:  grid_min_in[2]  = csr_data;
            CSR_CELL_SIZE_X: cell_size_in[0] = csr_data[30:0];
            CSR_CELL_SIZE_Y: cell_size_in[1] = csr_data[30:0];
            CSR_CELL_SIZE_Z: cell_size_in[2] = csr_data[30:0];
            CSR_CELLS:       cells_in        = csr_data[4:0];
            default:         cells_in        = cells_ff;
         endcase
      end

      // The output word leaves when taken.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (cmd.op)
         OP_LOAD: begin
            org_in[0] = req_word.origin_x;
            org_in[1] = req_word.origin_y;
            org_in[2] = req_word.origin_z;
            dir_in[0] = req_word.dir_x;
            dir_in[1] = req_word.dir_y;
            dir_in[2] = req_word.dir_z;
            en_in        = '0;
            ed_in        = 16'd1;
            xn_in        = '0;
            xd_in        = 16'd1;
            ok_in        = 1'b1;
            have_exit_in = 1'b0;
            cnt_in       = '0;
         end
         OP_PREP: begin
            for (int a = 0; a < 3; a++) begin
               hi_in[a] = HiW'(grid_min_ff[a]) + $signed({2'b0, span[a]});
               ad_in[a] = dir_ff[a][15] ? 16'(-dir_ff[a]) : 16'(dir_ff[a]);
            end
         end
         OP_SLAB_MUL: begin
            near_in = dpos ? (lo_s - o_s) : (o_s - hi_s);
            far_in  = dpos ? (hi_s - o_s) : (o_s - lo_s);
            pa_in   = ProdW'(near_in) * ProdW'($signed({1'b0, ed_ff}));
            pb_in   = ProdW'(en_ff) * ProdW'($signed({1'b0, ad_s}));
            pc_in   = ProdW'(far_in) * ProdW'($signed({1'b0, xd_ff}));
            pd_in   = ProdW'(xn_ff) * ProdW'($signed({1'b0, ad_s}));
         end
         OP_SLAB_UPD: begin
            if (dzero) begin
               if ((o_s < lo_s) || (o_s > hi_s)) begin
                  ok_in = 1'b0;
               end
            end else begin
               if (pa_ff > pb_ff) begin
                  en_in = near_ff;
                  ed_in = ad_s;
               end
               if (!have_exit_ff || (pc_ff < pd_ff)) begin
                  xn_in        = far_ff;
                  xd_in        = ad_s;
                  have_exit_in = 1'b1;
               end
            end
         end
         OP_CHK_MUL: begin
            pa_in = ProdW'(en_ff) * ProdW'($signed({1'b0, xd_ff}));
            pb_in = ProdW'(xn_ff) * ProdW'($signed({1'b0, ed_ff}));
         end
         OP_ENT_MUL: begin
            pa_in  = ProdW'(o_s - lo_s) * ProdW'($signed({1'b0, ed_ff}));
            pb_in  = ProdW'(d_s) * ProdW'(en_ff);
            den_in = DenW'(cs_s) * DenW'(ed_ff);
         end
         OP_DIV_INIT: begin
            neg_in = num[NumW-1];
            rem_in = num[ProdW-1:0];
            sat_in = num[ProdW-1:0] >= {5'b0, den_ff, 4'b0};
            q_in   = 4'd0;
         end
         OP_DIV_STEP: begin
            if (rem_ff >= dshift) begin
               rem_in            = rem_ff - dshift;
               q_in[cmd.bit_idx] = 1'b1;
            end
         end
         OP_DIST: begin
            c_in[cmd.axis] = cfin;
            if (dzero) begin
               dist_in[cmd.axis] = '0;
            end else if (dpos) begin
               dist_in[cmd.axis] = plane - o_s;
            end else begin
               dist_in[cmd.axis] = o_s - plane;
            end
         end
         OP_PROD: begin
            for (int b = 0; b < 3; b++) begin
               p_in[cmd.axis][b] = PW'(dist_ff[cmd.axis]) * PW'($signed({1'b0, ad_ff[b]}));
               k_in[cmd.axis][b] = KW'(cs_s) * KW'(ad_ff[b]);
            end
         end
         OP_WALK: begin
            rsp_valid_in       = 1'b1;
            rsp_word_in.cell_x = c_ff[0];
            rsp_word_in.cell_y = c_ff[1];
            rsp_word_in.cell_z = c_ff[2];
            rsp_word_in.hit    = 1'b1;
            rsp_word_in.last   = last_w;
            cnt_in             = cnt_ff + CntW'(1);
            if (best_ok) begin
               c_in[best] = dir_ff[best][15] ? (c_ff[best] - 4'd1) : (c_ff[best] + 4'd1);
               for (int b = 0; b < 3; b++) begin
                  p_in[best][b] = p_ff[best][b] + $signed({11'b0, k_ff[best][b]});
               end
            end
         end
         OP_MISS: begin
            rsp_valid_in       = 1'b1;
            rsp_word_in.cell_x = 4'd0;
            rsp_word_in.cell_y = 4'd0;
            rsp_word_in.cell_z = 4'd0;
            rsp_word_in.hit    = 1'b0;
            rsp_word_in.last   = 1'b1;
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   // Control registers and the output flag are reset; the rest is payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            grid_min_ff[a]  <= '0;
            cell_size_ff[a] <= 31'd65536;
         end
         cells_ff     <= 5'(MaxCells);
         rsp_valid_ff <= 1'b0;
      end else begin
         grid_min_ff  <= grid_min_in;
         cell_size_ff <= cell_size_in;
         cells_ff     <= cells_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      org_ff       <= org_in;
      dir_ff       <= dir_in;
      hi_ff        <= hi_in;
      ad_ff        <= ad_in;
      en_ff        <= en_in;
      ed_ff        <= ed_in;
      xn_ff        <= xn_in;
      xd_ff        <= xd_in;
      ok_ff        <= ok_in;
      have_exit_ff <= have_exit_in;
      near_ff      <= near_in;
      far_ff       <= far_in;
      pa_ff        <= pa_in;
      pb_ff        <= pb_in;
      pc_ff        <= pc_in;
      pd_ff        <= pd_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      q_ff         <= q_in;
      neg_ff       <= neg_in;
      sat_ff       <= sat_in;
      c_ff         <= c_in;
      dist_ff      <= dist_in;
      p_ff         <= p_in;
      k_ff         <= k_in;
      cnt_ff       <= cnt_in;
      rsp_word_ff  <= rsp_word_in;
   end

   // Status back to the controller.
   always_comb begin
      stat.pass      = ok_ff && !(have_exit_ff && (pa_ff > pb_ff));
      stat.walk_last = last_w;
      stat.slot_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

FILE: bench/ray_voxel_grid_traversal_test.sv
`timescale 1ns / 1ps
module ray_voxel_grid_traversal_test;
   import rvgt_pkg::*;

   localparam int     CycleLimit = 2000000;
   localparam longint WordMin    = -64'sd2147483648;
   localparam longint WordMax    = 64'sd2147483647;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_word_type        req_word = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_word_type        rsp_word;
   logic                csr_write = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = CSR_GRID_MIN_X;
   logic [31:0]         csr_data = '0;

   // Bench copy of the control registers.
   logic signed [31:0]  grid_min_reg [3];
   logic [30:0]         cell_size_reg [3];
   logic [4:0]          cells_reg;

   rsp_word_type        expected_cells [$];
   int                  mismatches = 0;
   int                  rays_sent = 0;
   int                  words_seen = 0;
   int                  cycles = 0;
   int                  send_idle_pct = 0;
   int                  stall_pct = 0;

   ray_voxel_grid_traversal uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Appends one expected word at the tail of the queue.
   function automatic void queue_word(input rsp_word_type r);
      expected_cells.insert(expected_cells.size(), r);
   endfunction

   // Works out every cell that one ray visits, in order, and queues the words.
   function automatic void predict_cells(input req_word_type w);
      longint n, en, ed, xn, xd, nearv, farv;
      longint lo[3], hi[3], cs[3], o[3], d[3], ad[3], c[3], plane_gap[3];
      bit have_exit, ok;
      int best, count;
      rsp_word_type r;
      en = 0; ed = 1; xn = 0; xd = 1; have_exit = 0; ok = 1; count = 0;
      n = (cells_reg == 0) ? 1 : ((cells_reg > MaxCells) ? MaxCells : cells_reg);
      o[0] = w.origin_x; o[1] = w.origin_y; o[2] = w.origin_z;
      d[0] = w.dir_x; d[1] = w.dir_y; d[2] = w.dir_z;
      for (int a = 0; a < 3; a++) begin
         cs[a] = (cell_size_reg[a] == 0) ? 1 : longint'(cell_size_reg[a]);
         lo[a] = grid_min_reg[a];
         hi[a] = lo[a] + cs[a] * n;
         ad[a] = (d[a] < 0) ? -d[a] : d[a];
      end
      // Slab test, times held as distance over direction magnitude.
      for (int a = 0; a < 3; a++) begin
         if (d[a] == 0) begin
            if (o[a] < lo[a] || o[a] > hi[a]) ok = 0;
            continue;
         end
         if (d[a] > 0) begin
            nearv = lo[a] - o[a]; farv = hi[a] - o[a];
         end else begin
            nearv = o[a] - hi[a]; farv = o[a] - lo[a];
         end
         if (nearv * ed > en * ad[a]) begin
            en = nearv; ed = ad[a];
         end
         if (!have_exit || farv * xd < xn * ad[a]) begin
            xn = farv; xd = ad[a]; have_exit = 1;
         end
      end
      if (ok && have_exit && en * xd > xn * ed) ok = 0;
      if (!ok) begin
         r = '0;
         r.last = 1'b1;
         queue_word(r);
         return;
      end
      // Entry cell by exact floor division, then the distance to the next plane.
      for (int a = 0; a < 3; a++) begin
         longint num, den;
         num = (o[a] - lo[a]) * ed + d[a] * en;
         den = cs[a] * ed;
         c[a] = num / den;
         if ((num % den) != 0 && num < 0) c[a] = c[a] - 1;
         if (c[a] < 0) c[a] = 0;
         if (c[a] > n - 1) c[a] = n - 1;
         if (d[a] > 0) plane_gap[a] = lo[a] + (c[a] + 1) * cs[a] - o[a];
         else if (d[a] < 0) plane_gap[a] = o[a] - (lo[a] + c[a] * cs[a]);
         else plane_gap[a] = 0;
      end
      // Walk: step the axis with the earliest crossing, ties in x, y, z order.
      forever begin
         r.cell_x = c[0][3:0]; r.cell_y = c[1][3:0]; r.cell_z = c[2][3:0];
         r.hit = 1'b1; r.last = 1'b0;
         count++;
         if (count >= MaxResults) break;
         best = -1;
         for (int a = 0; a < 3; a++) begin
            if (d[a] == 0) continue;
            if (best < 0 || plane_gap[a] * ad[best] < plane_gap[best] * ad[a]) best = a;
         end
         if (best < 0) break;
         c[best] += (d[best] > 0) ? 1 : -1;
         plane_gap[best] += cs[best];
         if (c[best] < 0 || c[best] >= n) break;
         queue_word(r);
      end
      r.last = 1'b1;
      queue_word(r);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: %s got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // Result checker: every accepted word against the oldest expectation.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_seen++;
         if (expected_cells.size() == 0) begin
            report_mismatch("unexpected word, hit", rsp_word.hit, 0);
         end else begin
            want = expected_cells.pop_front();
            if (rsp_word.cell_x !== want.cell_x)
               report_mismatch("cell_x", rsp_word.cell_x, want.cell_x);
            if (rsp_word.cell_y !== want.cell_y)
               report_mismatch("cell_y", rsp_word.cell_y, want.cell_y);
            if (rsp_word.cell_z !== want.cell_z)
               report_mismatch("cell_z", rsp_word.cell_z, want.cell_z);
            if (rsp_word.hit !== want.hit)
               report_mismatch("hit", rsp_word.hit, want.hit);
            if (rsp_word.last !== want.last)
               report_mismatch("last", rsp_word.last, want.last);
         end
      end
   end

   // Receiver back-pressure.
   always @(posedge clock) begin
      rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
   end

   // Run limit.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Sends one ray word and waits until it is taken.
   task automatic send_ray(input req_word_type w);
      int gap;
      gap = 0;
      if (send_idle_pct > 0)
         while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      predict_cells(w);
      rays_sent++;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_fields(input longint ox, oy, oz, input int dx, dy, dz);
      req_word_type w;
      w.origin_x = ox[31:0]; w.origin_y = oy[31:0]; w.origin_z = oz[31:0];
      w.dir_x = dx[15:0]; w.dir_y = dy[15:0]; w.dir_z = dz[15:0];
      send_ray(w);
   endtask

   // Lets every expected word arrive, then a margin for the block to settle.
   task automatic drain_words();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_cells.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [31:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx <= CSR_GRID_MIN_Z) grid_min_reg[idx] = value;
      else if (idx <= CSR_CELL_SIZE_Z) cell_size_reg[idx - CSR_CELL_SIZE_X] = value[30:0];
      else if (idx == CSR_CELLS) cells_reg = value[4:0];
   endtask

   task automatic set_grid(input logic [31:0] mx, my, mz, sx, sy, sz, input logic [31:0] n);
      drain_words();
      write_reg(CSR_GRID_MIN_X, mx);
      write_reg(CSR_GRID_MIN_Y, my);
      write_reg(CSR_GRID_MIN_Z, mz);
      write_reg(CSR_CELL_SIZE_X, sx);
      write_reg(CSR_CELL_SIZE_Y, sy);
      write_reg(CSR_CELL_SIZE_Z, sz);
      write_reg(CSR_CELLS, n);
   endtask

   // Directed rays on the reset grid: 16 cells of 1.0 from the origin.
   task automatic test_directed();
      longint one;
      one = 65536;
      send_fields(one / 2, one / 2, one / 2, 16384, 0, 0);        // full walk along x
      send_fields(15 * one, one, one, -16384, 0, 0);              // walk back along x
      send_fields(one / 2, one / 2, one / 2, 9459, 9459, 9459);   // three-way ties
      send_fields(3 * one, 3 * one, 3 * one, 0, 0, 0);            // no direction
      send_fields(0, 0, 0, 0, 16384, 0);                          // origin on the boundary
      send_fields(16 * one, 16 * one, 16 * one, -9459, -9459, -9459); // far corner
      send_fields(-5 * one, one, one, 16384, 0, 0);               // enters from outside
      send_fields(-5 * one, one, one, -16384, 0, 0);              // points away: miss
      send_fields(20 * one, one, one, 0, 16384, 0);               // zero axis outside slab
      send_fields(24 * one, 2 * one, 3 * one, -16384, 0, 0);      // entry on the far face
      send_fields(WordMin, WordMin, WordMin, 32767, 32767, 32767);
      send_fields(WordMax, WordMax, WordMax, -32768, -32768, -32768);
      send_fields(WordMin, WordMax, 0, 32767, -32768, 1);
      send_fields(one / 2, one / 2, one / 2, 1, 32767, -1);
      send_fields(one * 8, one * 8, one * 8, -32768, 32767, -32768);
   endtask

   // Mostly rays aimed from around the box at a point inside it, some noise.
   task automatic random_rays(input int count);
      longint n, lo, span, tgt, delta[3], o[3], big;
      int dv[3];
      req_word_type w;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(9) == 0) begin
            w = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
            send_ray(w);
            continue;
         end
         n = (cells_reg == 0) ? 1 : ((cells_reg > MaxCells) ? MaxCells : cells_reg);
         big = 1;
         for (int a = 0; a < 3; a++) begin
            lo = grid_min_reg[a];
            span = ((cell_size_reg[a] == 0) ? 1 : longint'(cell_size_reg[a])) * n;
            o[a] = lo - span + longint'($urandom_range(1000)) * 3 * span / 1000;
            if (o[a] > WordMax) o[a] = WordMax;
            if (o[a] < WordMin) o[a] = WordMin;
            tgt = lo + longint'($urandom_range(1000)) * span / 1000;
            delta[a] = tgt - o[a];
            if ((delta[a] < 0 ? -delta[a] : delta[a]) > big)
               big = delta[a] < 0 ? -delta[a] : delta[a];
         end
         for (int a = 0; a < 3; a++) begin
            dv[a] = int'(delta[a] * 16384 / big);
            if ($urandom_range(7) == 0) dv[a] = 0;
         end
         send_fields(o[0], o[1], o[2], dv[0], dv[1], dv[2]);
      end
   endtask

   task automatic test_reset_grid_random();
      random_rays(52);
   endtask

   task automatic test_register_extremes();
      // Zero cell sizes and a cell count of zero.
      set_grid(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      send_fields(0, 0, 0, 16384, 0, 0);
      random_rays(8);
      // Count above the maximum, negative corner, largest cell sizes.
      set_grid(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h1F);
      send_fields(WordMin, WordMin, WordMin, 9459, 9459, 9459);
      random_rays(12);
      // Positive corner at the top, a single cell.
      set_grid(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h1);
      send_fields(WordMax, WordMax, WordMax, 0, 0, 0);
      random_rays(10);
   endtask

   task automatic test_random_grids(input int idle_pct, input int stall_p, input int rays);
      send_idle_pct = idle_pct;
      stall_pct = stall_p;
      for (int g = 0; g < rays / 15; g++) begin
         set_grid($urandom, $urandom, $urandom,
                  $urandom_range(1, 32'h4_0000), $urandom_range(1, 32'h4_0000),
                  ($urandom_range(5) == 0) ? $urandom : $urandom_range(1, 32'h4_0000),
                  $urandom_range(0, 31));
         random_rays(15);
      end
   endtask

   initial begin
      for (int a = 0; a < 3; a++) begin
         grid_min_reg[a] = '0;
         cell_size_reg[a] = 31'd65536;
      end
      cells_reg = 5'd16;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_reset_grid_random();
      test_register_extremes();
      test_random_grids(0, 0, 30);
      test_random_grids(58, 0, 30);
      test_random_grids(0, 58, 30);
      test_random_grids(15, 15, 30);
      drain_words();
      repeat (50) @(posedge clock);

      $display("Sent %0d rays over reset, extreme and random grids; checked %0d cell words.",
               rays_sent, words_seen);
      $display("Idling covered none, sender only, receiver only and both together.");
      if (mismatches == 0 && expected_cells.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d words never arrived", mismatches,
                  expected_cells.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
